/* rtl/tlblru_pkg.sv */
package tlblru_pkg;

    // Fixed field widths.
    localparam int FRAME_W = 20;
    localparam int STAMP_W = 32;
    localparam int CFG_W   = 5;
    localparam int EVPG_W  = 20;

    // Defaults for the top-level parameters.
    localparam int MAX_ENTRIES_DEF = 16;
    localparam int PAGE_BITS_DEF   = 20;

    // Value of the usable-entry register after reset.
    localparam logic [CFG_W-1:0] ENTRIES_RESET = 5'd16;

    // Request kinds.
    localparam logic KIND_LOOKUP = 1'b0;
    localparam logic KIND_INSERT = 1'b1;

    // Running results of the scan unit.
    typedef struct packed {
        logic have_match;
        logic have_free;
        logic have_old;
    } scan_flags_t;

endpackage

/* rtl/tlblru_store.sv */
module tlblru_store #(
    parameter int MAX_ENTRIES = tlblru_pkg::MAX_ENTRIES_DEF,
    parameter int PAGE_BITS   = tlblru_pkg::PAGE_BITS_DEF,
    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // Registered read port.
    input  logic [IDX_W-1:0]              rd_addr,
    output logic                          rd_valid,
    output logic [PAGE_BITS-1:0]          rd_page,
    output logic [tlblru_pkg::FRAME_W-1:0] rd_frame,
    output logic [tlblru_pkg::STAMP_W-1:0] rd_stamp,
    // Write port; a write always marks the entry valid.
    input  logic                          wr_en,
    input  logic [IDX_W-1:0]              wr_addr,
    input  logic [PAGE_BITS-1:0]          wr_page,
    input  logic [tlblru_pkg::FRAME_W-1:0] wr_frame,
    input  logic [tlblru_pkg::STAMP_W-1:0] wr_stamp,
    // Invalidate every entry at or above trim_cap.
    input  logic                          trim_en,
    input  logic [CNT_W-1:0]              trim_cap
);

    logic [PAGE_BITS-1:0]           page_mem  [MAX_ENTRIES];
    logic [tlblru_pkg::FRAME_W-1:0] frame_mem [MAX_ENTRIES];
    logic [tlblru_pkg::STAMP_W-1:0] stamp_mem [MAX_ENTRIES];

    logic [MAX_ENTRIES-1:0] valid_reg;
    logic [MAX_ENTRIES-1:0] valid_next;

    // Entry payload memory: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            page_mem[wr_addr]  <= wr_page;
            frame_mem[wr_addr] <= wr_frame;
            stamp_mem[wr_addr] <= wr_stamp;
        end
        rd_page  <= page_mem[rd_addr];
        rd_frame <= frame_mem[rd_addr];
        rd_stamp <= stamp_mem[rd_addr];
    end

    // Valid bits: set on write, cleared at or above the usable count on a trim.
    always_comb
    begin
        valid_next = valid_reg;
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            if (trim_en && (CNT_W'(i) >= trim_cap))
            begin
                valid_next[i] = 1'b0;
            end
        end
        if (wr_en)
        begin
            valid_next[wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            rd_valid  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            rd_valid  <= valid_reg[rd_addr];
        end
    end

endmodule

/* rtl/tlblru_scan.sv */
module tlblru_scan #(
    parameter int MAX_ENTRIES = tlblru_pkg::MAX_ENTRIES_DEF,
    parameter int PAGE_BITS   = tlblru_pkg::PAGE_BITS_DEF,
    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           clear,
    input  logic                           step,
    input  logic [IDX_W-1:0]               idx,
    input  logic [PAGE_BITS-1:0]           key_page,
    input  logic                           ent_valid,
    input  logic [PAGE_BITS-1:0]           ent_page,
    input  logic [tlblru_pkg::FRAME_W-1:0] ent_frame,
    input  logic [tlblru_pkg::STAMP_W-1:0] ent_stamp,
    output tlblru_pkg::scan_flags_t        flags,
    output logic [IDX_W-1:0]               found_idx,
    output logic [IDX_W-1:0]               free_idx,
    output logic [IDX_W-1:0]               oldest_idx,
    output logic [tlblru_pkg::FRAME_W-1:0] match_frame,
    output logic [PAGE_BITS-1:0]           oldest_page
);

    tlblru_pkg::scan_flags_t        flags_reg;
    tlblru_pkg::scan_flags_t        flags_next;
    logic [IDX_W-1:0]               found_idx_reg;
    logic [IDX_W-1:0]               free_idx_reg;
    logic [IDX_W-1:0]               oldest_idx_reg;
    logic [tlblru_pkg::FRAME_W-1:0] match_frame_reg;
    logic [PAGE_BITS-1:0]           oldest_page_reg;
    logic [tlblru_pkg::STAMP_W-1:0] oldest_stamp_reg;
    logic                           take_match;
    logic                           take_old;
    logic                           take_free;

    // One entry per step: page match, free slot and oldest stamp.
    always_comb
    begin
        take_match = step && ent_valid && !flags_reg.have_match && (ent_page == key_page);
        take_old   = step && ent_valid &&
                     (!flags_reg.have_old || (ent_stamp < oldest_stamp_reg));
        take_free  = step && !ent_valid && !flags_reg.have_free;
        flags_next = flags_reg;
        if (clear)
        begin
            flags_next = '0;
        end
        else
        begin
            if (take_match)
            begin
                flags_next.have_match = 1'b1;
            end
            if (take_old)
            begin
                flags_next.have_old = 1'b1;
            end
            if (take_free)
            begin
                flags_next.have_free = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
        end
        else
        begin
            flags_reg <= flags_next;
        end
    end

    // Captured entry data; only meaningful once the matching flag is set.
    always_ff @(posedge clk)
    begin
        if (!clear && take_match)
        begin
            found_idx_reg   <= idx;
            match_frame_reg <= ent_frame;
        end
        if (!clear && take_old)
        begin
            oldest_idx_reg   <= idx;
            oldest_page_reg  <= ent_page;
            oldest_stamp_reg <= ent_stamp;
        end
        if (!clear && take_free)
        begin
            free_idx_reg <= idx;
        end
    end

    assign flags       = flags_reg;
    assign found_idx   = found_idx_reg;
    assign free_idx    = free_idx_reg;
    assign oldest_idx  = oldest_idx_reg;
    assign match_frame = match_frame_reg;
    assign oldest_page = oldest_page_reg;

endmodule

/* rtl/tlb_lru_lookup_insert_core.sv */
// Channel  Dir  Handshake                    Payload
// s_axis   in   s_axis_tvalid/s_axis_tready  tdata: page_number, frame_in, time_stamp;
//                                            tuser: kind
// m_axis   out  m_axis_tvalid/m_axis_tready  tdata: frame_out, evicted_page;
//                                            tuser: hit, evicted
// cfg      in   cfg_we                       cfg_wdata: entries_in_use
//
// One request is in flight at a time. A request scans the usable entries one per
// cycle through the single read port of the entry memory and one compare unit;
// a drain step and a write-back step follow the scan before the result is valid,
// and the next request can be taken in the cycle after the result is taken.
// With zero usable entries the all-zero result is valid on the cycle after acceptance.
// Reset empties the buffer and sets the usable count to 16; a stalled result holds.
module tlb_lru_lookup_insert_core #(
    parameter int MAX_ENTRIES = tlblru_pkg::MAX_ENTRIES_DEF,
    parameter int PAGE_BITS   = tlblru_pkg::PAGE_BITS_DEF,
    localparam int IN_W  = ((PAGE_BITS + tlblru_pkg::FRAME_W + tlblru_pkg::STAMP_W + 7) / 8) * 8,
    localparam int OUT_W = ((tlblru_pkg::FRAME_W + tlblru_pkg::EVPG_W + 7) / 8) * 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // page_number, frame_in, time_stamp, zero pad
    input  logic [IN_W-1:0]              s_axis_tdata,
    // kind
    input  logic                         s_axis_tuser,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // frame_out, evicted_page
    output logic [OUT_W-1:0]             m_axis_tdata,
    // hit, evicted
    output logic [1:0]                   m_axis_tuser,
    input  logic                         cfg_we,
    input  logic [tlblru_pkg::CFG_W-1:0] cfg_wdata
);

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int FW    = tlblru_pkg::FRAME_W;
    localparam int SW    = tlblru_pkg::STAMP_W;
    localparam int EW    = tlblru_pkg::EVPG_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_WRITE = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [2:0]                   state_reg;
    logic [2:0]                   state_next;
    logic [tlblru_pkg::CFG_W-1:0] entries_reg;
    logic [CNT_W-1:0]             cap;
    logic [CNT_W-1:0]             new_cap;
    logic [IDX_W-1:0]             scan_idx_reg;
    logic [IDX_W-1:0]             scan_idx_next;
    logic                         cmp_step_reg;
    logic [IDX_W-1:0]             cmp_idx_reg;
    logic                         scan_clear;

    logic                         key_kind_reg;
    logic [PAGE_BITS-1:0]         key_page_reg;
    logic [FW-1:0]                key_frame_reg;
    logic [SW-1:0]                key_stamp_reg;

    logic                         out_hit_reg;
    logic                         out_evicted_reg;
    logic [FW-1:0]                out_frame_reg;
    logic [EW-1:0]                out_evpage_reg;

    logic                         ent_valid;
    logic [PAGE_BITS-1:0]         ent_page;
    logic [FW-1:0]                ent_frame;
    logic [SW-1:0]                ent_stamp;
    logic                         wr_en;
    logic [IDX_W-1:0]             wr_addr;
    logic [FW-1:0]                wr_frame;

    tlblru_pkg::scan_flags_t      flags;
    logic [IDX_W-1:0]             found_idx;
    logic [IDX_W-1:0]             free_idx;
    logic [IDX_W-1:0]             oldest_idx;
    logic [FW-1:0]                match_frame;
    logic [PAGE_BITS-1:0]         oldest_page;
    logic [EW-1:0]                oldest_page_ext;

    logic                         in_fire;
    logic                         scan_last;

    // Usable count, saturated at the table size, now and for a pending write.
    always_comb
    begin
        if (32'(entries_reg) > MAX_ENTRIES)
        begin
            cap = CNT_W'(MAX_ENTRIES);
        end
        else
        begin
            cap = CNT_W'(entries_reg);
        end
        if (32'(cfg_wdata) > MAX_ENTRIES)
        begin
            new_cap = CNT_W'(MAX_ENTRIES);
        end
        else
        begin
            new_cap = CNT_W'(cfg_wdata);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries_reg <= tlblru_pkg::ENTRIES_RESET;
        end
        else if (cfg_we)
        begin
            entries_reg <= cfg_wdata;
        end
    end

    assign in_fire   = s_axis_tvalid && s_axis_tready;
    assign scan_last = (CNT_W'(scan_idx_reg) + CNT_W'(1)) == cap;

    // Sequencer.
    always_comb
    begin
        state_next    = state_reg;
        scan_idx_next = scan_idx_reg;
        scan_clear    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    scan_idx_next = '0;
                    scan_clear    = 1'b1;
                    state_next    = (cap == '0) ? S_OUT : S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + IDX_W'(1);
                end
            end
            S_DRAIN:
            begin
                state_next = S_WRITE;
            end
            S_WRITE:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (m_axis_tready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            scan_idx_reg <= '0;
            cmp_step_reg <= 1'b0;
            cmp_idx_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            scan_idx_reg <= scan_idx_next;
            cmp_step_reg <= (state_reg == S_SCAN);
            cmp_idx_reg  <= scan_idx_reg;
        end
    end

    // Request fields.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            key_kind_reg  <= s_axis_tuser;
            key_page_reg  <= s_axis_tdata[PAGE_BITS-1:0];
            key_frame_reg <= s_axis_tdata[PAGE_BITS +: FW];
            key_stamp_reg <= s_axis_tdata[PAGE_BITS + FW +: SW];
        end
    end

    // Write-back decision at the end of the scan.
    always_comb
    begin
        wr_en    = (state_reg == S_WRITE);
        wr_addr  = found_idx;
        wr_frame = key_frame_reg;
        if (key_kind_reg == tlblru_pkg::KIND_LOOKUP)
        begin
            wr_en    = wr_en && flags.have_match;
            wr_frame = match_frame;
        end
        else if (!flags.have_match)
        begin
            wr_addr = flags.have_free ? free_idx : oldest_idx;
        end
    end

    if (PAGE_BITS >= EW)
    begin : g_evpg_trunc
        assign oldest_page_ext = oldest_page[EW-1:0];
    end
    else
    begin : g_evpg_ext
        assign oldest_page_ext = EW'(oldest_page);
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_hit_reg     <= 1'b0;
            out_evicted_reg <= 1'b0;
            out_frame_reg   <= '0;
            out_evpage_reg  <= '0;
        end
        else if (in_fire)
        begin
            out_hit_reg     <= 1'b0;
            out_evicted_reg <= 1'b0;
            out_frame_reg   <= '0;
            out_evpage_reg  <= '0;
        end
        else if (state_reg == S_WRITE)
        begin
            if (key_kind_reg == tlblru_pkg::KIND_LOOKUP)
            begin
                if (flags.have_match)
                begin
                    out_hit_reg   <= 1'b1;
                    out_frame_reg <= match_frame;
                end
            end
            else if (!flags.have_match && !flags.have_free)
            begin
                out_evicted_reg <= 1'b1;
                out_evpage_reg  <= oldest_page_ext;
            end
        end
    end

    tlblru_store #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .PAGE_BITS   (PAGE_BITS)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_addr  (scan_idx_reg),
        .rd_valid (ent_valid),
        .rd_page  (ent_page),
        .rd_frame (ent_frame),
        .rd_stamp (ent_stamp),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_page  (key_page_reg),
        .wr_frame (wr_frame),
        .wr_stamp (key_stamp_reg),
        .trim_en  (cfg_we),
        .trim_cap (new_cap)
    );

    tlblru_scan #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .PAGE_BITS   (PAGE_BITS)
    ) u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .clear       (scan_clear),
        .step        (cmp_step_reg),
        .idx         (cmp_idx_reg),
        .key_page    (key_page_reg),
        .ent_valid   (ent_valid),
        .ent_page    (ent_page),
        .ent_frame   (ent_frame),
        .ent_stamp   (ent_stamp),
        .flags       (flags),
        .found_idx   (found_idx),
        .free_idx    (free_idx),
        .oldest_idx  (oldest_idx),
        .match_frame (match_frame),
        .oldest_page (oldest_page)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = (state_reg == S_OUT);
    assign m_axis_tdata  = OUT_W'({out_evpage_reg, out_frame_reg});
    assign m_axis_tuser  = {out_evicted_reg, out_hit_reg};

    // The block never takes a request while a result is pending.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("request accepted while a result is pending");

    // A result never reports both a hit and an eviction.
    a_hit_evict: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
        else $error("hit and eviction reported together");

    // A disabled buffer answers on the next cycle with an all-zero result.
    a_disabled: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (cap == '0)) |=>
            (m_axis_tvalid && (m_axis_tuser == '0) && (m_axis_tdata == '0)))
        else $error("disabled buffer gave a nonzero or late result");

    // The scan address stays below the usable count.
    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (CNT_W'(scan_idx_reg) < cap))
        else $error("scan address beyond the usable entries");

endmodule

/* tb/tb.sv */
module tb;

    localparam int SLOTS     = tlblru_pkg::MAX_ENTRIES_DEF;
    localparam int PAGE_W    = tlblru_pkg::PAGE_BITS_DEF;
    localparam int FRAME_W   = tlblru_pkg::FRAME_W;
    localparam int STAMP_W   = tlblru_pkg::STAMP_W;
    localparam int EVPG_W    = tlblru_pkg::EVPG_W;
    localparam int CFG_W     = tlblru_pkg::CFG_W;
    localparam int IN_W      = ((PAGE_W + FRAME_W + STAMP_W + 7) / 8) * 8;
    localparam int OUT_W     = ((FRAME_W + EVPG_W + 7) / 8) * 8;
    localparam int SETTLE    = 4;
    localparam int TAIL_WAIT = 25;

    typedef struct {
        logic              hit;
        logic [FRAME_W-1:0] frame_out;
        logic              evicted;
        logic [EVPG_W-1:0]  evicted_page;
    } tlb_result_t;

    logic               clk;
    logic               rst_n;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    // page_number, frame_in, time_stamp
    logic [IN_W-1:0]    s_axis_tdata;
    // kind
    logic               s_axis_tuser;
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    // frame_out, evicted_page
    logic [OUT_W-1:0]   m_axis_tdata;
    // hit, evicted
    logic [1:0]         m_axis_tuser;
    logic               cfg_we;
    logic [CFG_W-1:0]   cfg_wdata;

    // Mirror of the translation buffer contents and its usable-entry register.
    logic [CFG_W-1:0]   mirror_entries;
    logic               mirror_valid [SLOTS];
    logic [PAGE_W-1:0]  mirror_page  [SLOTS];
    logic [FRAME_W-1:0] mirror_frame [SLOTS];
    logic [STAMP_W-1:0] mirror_stamp [SLOTS];

    tlb_result_t        expected_translations[$];
    int                 error_count;
    int                 sender_idle_pct;
    int                 receiver_stall_pct;
    logic [STAMP_W-1:0] virtual_clock;
    logic [PAGE_W-1:0]  page_pool [24];

    tlb_lru_lookup_insert_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #3000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Number of slots the buffer may use for a register value.
    function automatic int usable_slots(input logic [CFG_W-1:0] value);
        return (value > SLOTS) ? SLOTS : int'(value);
    endfunction

    // Register write: slots beyond the new usable count are dropped.
    function automatic void mirror_set_entries(input logic [CFG_W-1:0] value);
        int cap;
        cap = usable_slots(value);
        mirror_entries = value;
        for (int i = cap; i < SLOTS; i++)
        begin
            mirror_valid[i] = 1'b0;
        end
    endfunction

    // Computes the outcome of one request and updates the mirror.
    function automatic tlb_result_t translate_and_update(input logic kind,
                                                          input logic [PAGE_W-1:0] page,
                                                          input logic [FRAME_W-1:0] frame,
                                                          input logic [STAMP_W-1:0] stamp);
        tlb_result_t res;
        int          cap;
        int          match_idx;
        int          free_idx;
        int          oldest_idx;
        cap        = usable_slots(mirror_entries);
        match_idx  = -1;
        free_idx   = -1;
        oldest_idx = -1;
        res        = '{1'b0, '0, 1'b0, '0};
        if (cap == 0)
        begin
            return res;
        end

        // One pass finds the first match, the first free slot and the oldest entry.
        for (int i = 0; i < cap; i++)
        begin
            if (mirror_valid[i])
            begin
                if (match_idx < 0 && mirror_page[i] == page)
                begin
                    match_idx = i;
                end
                if (oldest_idx < 0 || mirror_stamp[i] < mirror_stamp[oldest_idx])
                begin
                    oldest_idx = i;
                end
            end
            else if (free_idx < 0)
            begin
                free_idx = i;
            end
        end

        if (kind == tlblru_pkg::KIND_LOOKUP)
        begin
            if (match_idx >= 0)
            begin
                mirror_stamp[match_idx] = stamp;
                res.hit       = 1'b1;
                res.frame_out = mirror_frame[match_idx];
            end
            return res;
        end

        // Insert of a page already present rewrites it in place.
        if (match_idx >= 0)
        begin
            mirror_frame[match_idx] = frame;
            mirror_stamp[match_idx] = stamp;
            return res;
        end

        // Full buffer: the least recently used entry makes room.
        if (free_idx < 0)
        begin
            res.evicted      = 1'b1;
            res.evicted_page = mirror_page[oldest_idx];
            free_idx         = oldest_idx;
        end
        mirror_valid[free_idx] = 1'b1;
        mirror_page[free_idx]  = page;
        mirror_frame[free_idx] = frame;
        mirror_stamp[free_idx] = stamp;
        return res;
    endfunction

    // Receiver side: randomly withholds tready.
    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // Compares every accepted result with the oldest expected one.
    always @(posedge clk)
    begin
        tlb_result_t want;
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (expected_translations.size() == 0)
            begin
                $display("%0t: unexpected result tdata=%h tuser=%b",
                         $time, m_axis_tdata, m_axis_tuser);
                error_count++;
            end
            else
            begin
                want = expected_translations.pop_front();
                if (m_axis_tuser[0] !== want.hit)
                begin
                    $display("%0t: hit expected %b actual %b", $time, want.hit, m_axis_tuser[0]);
                    error_count++;
                end
                if (m_axis_tdata[FRAME_W-1:0] !== want.frame_out)
                begin
                    $display("%0t: frame_out expected %h actual %h",
                             $time, want.frame_out, m_axis_tdata[FRAME_W-1:0]);
                    error_count++;
                end
                if (m_axis_tuser[1] !== want.evicted)
                begin
                    $display("%0t: evicted expected %b actual %b",
                             $time, want.evicted, m_axis_tuser[1]);
                    error_count++;
                end
                if (m_axis_tdata[FRAME_W+EVPG_W-1:FRAME_W] !== want.evicted_page)
                begin
                    $display("%0t: evicted_page expected %h actual %h",
                             $time, want.evicted_page,
                             m_axis_tdata[FRAME_W+EVPG_W-1:FRAME_W]);
                    error_count++;
                end
            end
        end
    end

    // Sends one request, after an optional random gap, and records its outcome.
    task automatic send_request(input logic kind, input logic [PAGE_W-1:0] page,
                                input logic [FRAME_W-1:0] frame,
                                input logic [STAMP_W-1:0] stamp);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {stamp, frame, page};
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        expected_translations.insert(expected_translations.size(),
                                     translate_and_update(kind, page, frame, stamp));
    endtask

    // Stops sending and waits until every outstanding result is back.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (expected_translations.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    // Writes the usable-entry register while the block is idle.
    task automatic write_entries_in_use(input logic [CFG_W-1:0] value);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        mirror_set_entries(value);
        @(posedge clk);
    endtask

    // Mostly rising time stamps, with repeats for ties and occasional jumps.
    function automatic logic [STAMP_W-1:0] next_stamp();
        int pick;
        pick = $urandom_range(99);
        if (pick < 70)
        begin
            virtual_clock = virtual_clock + $urandom_range(50, 1);
        end
        else if (pick >= 85)
        begin
            return $urandom;
        end
        return virtual_clock;
    endfunction

    // Hits, misses, insert of a present page and the field extremes.
    task automatic test_lookup_insert_basics();
        send_request(tlblru_pkg::KIND_LOOKUP, 20'h00000, 20'hFFFFF, 32'h0000_0000);
        send_request(tlblru_pkg::KIND_INSERT, 20'h00000, 20'hFFFFF, 32'h0000_0000);
        send_request(tlblru_pkg::KIND_LOOKUP, 20'h00000, 20'h00000, 32'h0000_0064);
        send_request(tlblru_pkg::KIND_INSERT, 20'hFFFFF, 20'h00000, 32'hFFFF_FFFF);
        send_request(tlblru_pkg::KIND_LOOKUP, 20'hFFFFF, 20'hABCDE, 32'hFFFF_FFFF);
        send_request(tlblru_pkg::KIND_INSERT, 20'h00000, 20'h12345, 32'h0000_00C8);
        send_request(tlblru_pkg::KIND_LOOKUP, 20'h00000, 20'h00000, 32'h0000_00C8);
        send_request(tlblru_pkg::KIND_INSERT, 20'h00ABC, 20'h54321, 32'h0000_0032);
        send_request(tlblru_pkg::KIND_INSERT, 20'h00DEF, 20'h00001, 32'h0000_003C);
    endtask

    // Shrinking drops upper slots; a full buffer evicts the oldest, lowest index on ties.
    task automatic test_shrink_and_eviction();
        write_entries_in_use(5'd2);
        send_request(tlblru_pkg::KIND_LOOKUP, 20'h00ABC, 20'h00000, 32'h0000_012C);
        send_request(tlblru_pkg::KIND_INSERT, 20'h11111, 20'h0AAAA, 32'h0000_012C);
        send_request(tlblru_pkg::KIND_INSERT, 20'h22222, 20'h05555, 32'h0000_012C);
        send_request(tlblru_pkg::KIND_LOOKUP, 20'hFFFFF, 20'h00000, 32'h0000_012C);
        send_request(tlblru_pkg::KIND_INSERT, 20'h33333, 20'h0F0F0, 32'h0000_0190);
    endtask

    // Zero entries disable the buffer; values above capacity saturate.
    task automatic test_disabled_and_saturation();
        write_entries_in_use(5'd0);
        send_request(tlblru_pkg::KIND_LOOKUP, 20'h33333, 20'h00000, 32'h0000_01F4);
        send_request(tlblru_pkg::KIND_INSERT, 20'h44444, 20'h0BEEF, 32'h0000_01F4);
        write_entries_in_use(5'd31);
        send_request(tlblru_pkg::KIND_LOOKUP, 20'h33333, 20'h00000, 32'h0000_0258);
        send_request(tlblru_pkg::KIND_INSERT, 20'h55555, 20'h0CAFE, 32'h0000_0001);
        write_entries_in_use(5'd17);
        send_request(tlblru_pkg::KIND_LOOKUP, 20'h55555, 20'h00000, 32'h0000_0002);
    endtask

    // A single usable entry is evicted by every new page.
    task automatic test_single_entry();
        write_entries_in_use(5'd1);
        send_request(tlblru_pkg::KIND_INSERT, 20'h66666, 20'h00777, 32'h0000_0000);
        send_request(tlblru_pkg::KIND_INSERT, 20'h66666, 20'h00888, 32'h0000_0010);
        send_request(tlblru_pkg::KIND_LOOKUP, 20'h66666, 20'h00000, 32'h0000_0020);
        send_request(tlblru_pkg::KIND_INSERT, 20'h77777, 20'h00999, 32'h0000_0030);
    endtask

    // Random traffic over a small page set per segment, across idling phases.
    task automatic test_random_traffic();
        logic [CFG_W-1:0]   segment_entries [8];
        int                 segment_items;
        int                 pool_size;
        logic [PAGE_W-1:0]  page;
        logic               kind;
        segment_entries = '{5'd16, 5'd4, 5'd1, 5'd31, 5'd0, 5'd2, 5'd17, 5'd8};
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
                1:
                begin
                    sender_idle_pct    = 84;
                    receiver_stall_pct = 0;
                end
                2:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 84;
                end
                default:
                begin
                    sender_idle_pct    = 37;
                    receiver_stall_pct = 37;
                end
            endcase
            for (int seg = 0; seg < 2; seg++)
            begin
                write_entries_in_use((phase == 3 && seg == 1) ?
                                     CFG_W'($urandom_range(31)) : segment_entries[phase*2+seg]);
                segment_items = (segment_entries[phase*2+seg] == 0) ? 20 : 130;
                pool_size     = $urandom_range(24, 3);
                for (int i = 0; i < pool_size; i++)
                begin
                    page_pool[i] = PAGE_W'($urandom);
                end
                for (int n = 0; n < segment_items; n++)
                begin
                    kind = ($urandom_range(1) == 1) ? tlblru_pkg::KIND_INSERT
                                                    : tlblru_pkg::KIND_LOOKUP;
                    page = ($urandom_range(99) < 90) ? page_pool[$urandom_range(pool_size-1)]
                                                     : PAGE_W'($urandom);
                    send_request(kind, page, FRAME_W'($urandom), next_stamp());
                end
            end
        end
    endtask

    // Test sequence.
    initial
    begin
        rst_n              = 1'b0;
        s_axis_tvalid      = 1'b0;
        s_axis_tdata       = '0;
        s_axis_tuser       = tlblru_pkg::KIND_LOOKUP;
        m_axis_tready      = 1'b0;
        cfg_we             = 1'b0;
        cfg_wdata          = '0;
        error_count        = 0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        virtual_clock      = 32'h0000_1000;
        mirror_entries     = tlblru_pkg::ENTRIES_RESET;
        for (int i = 0; i < SLOTS; i++)
        begin
            mirror_valid[i] = 1'b0;
            mirror_page[i]  = '0;
            mirror_frame[i] = '0;
            mirror_stamp[i] = '0;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_lookup_insert_basics();
        test_shrink_and_eviction();
        test_disabled_and_saturation();
        test_single_entry();
        test_random_traffic();

        drain_results();
        repeat (TAIL_WAIT) @(posedge clk);
        if (error_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/tlblru_pkg.sv
rtl/tlblru_store.sv
rtl/tlblru_scan.sv
rtl/tlb_lru_lookup_insert_core.sv
tb/tb.sv
